FILE: src/mqsb_pkg.sv
// shared types and constants for the multi-queue shared buffer
`default_nettype none

package mqsb_pkg;

    // fixed port widths
    localparam int QID_WIDTH  = 2;
    localparam int DATA_PORT_WIDTH = 32;

    typedef enum logic
    {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

endpackage

`default_nettype wire

FILE: src/multi_queue_shared_buffer.sv
// multi-queue shared buffer: per-queue linked lists and a free list in one payload store
//
//   channel  dir  handshake           fields
//   -------  ---  ------------------  ------------------------------
//   in       in   in_valid/in_ready   op, queue_id, data_in
//   out      out  out_valid/out_ready data_out, status
//
// one beat in and one beat out per cycle sustained unless the output stalls; a command is
// taken into the execute register when accepted and then into the output register
// the successor of the free head is read from the link store every cycle, registered,
// and used by the next enqueue
// reset is immediate: never-issued entries are tracked by a fresh pointer, no clearing pass
// a stalled output holds the execute stage, which in turn drops in_ready
`default_nettype none

module multi_queue_shared_buffer
    import mqsb_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int QUEUES     = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic [QID_WIDTH-1:0]              queue_id,
    input  logic signed [DATA_PORT_WIDTH-1:0] data_in,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [DATA_PORT_WIDTH-1:0] data_out,
    output logic [1:0]                        status
);

    // entry index, free count and queue index widths
    localparam int IW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    // queue number widened so that range checks against QUEUES are exact
    localparam int QXW = QW + QID_WIDTH;

    // ------------------------------------------------------------------
    // storage
    // ------------------------------------------------------------------
    // link store: successor of each entry on its chain (free list or a queue)
    logic [IW-1:0]         link_mem [DEPTH];
    // payload store
    logic [DATA_WIDTH-1:0] pay_mem  [DEPTH];

    // free list control
    logic [IW-1:0] free_head_reg,  free_head_next;
    logic [CW-1:0] free_count_reg, free_count_next;
    // entries at or above the fresh pointer were never handed out, so their successor is
    // taken as the reset successor (index plus one, wrapping), not read from the link store
    logic [CW-1:0] fresh_reg,      fresh_next;

    // per-queue pointers and occupancy
    logic [IW-1:0]     head_reg [QUEUES];
    logic [IW-1:0]     head_next [QUEUES];
    logic [IW-1:0]     tail_reg [QUEUES];
    logic [IW-1:0]     tail_next [QUEUES];
    logic [QUEUES-1:0] nonempty_reg, nonempty_next;

    // ------------------------------------------------------------------
    // execute stage register (the accepted command)
    // ------------------------------------------------------------------
    logic                  e_valid_reg;
    op_t                   e_op_reg;
    logic [QID_WIDTH-1:0]  e_qid_reg;
    logic [DATA_WIDTH-1:0] e_data_reg;

    // registered memory reads feeding the execute stage
    // free-head successor, read every cycle at the next free head
    logic [IW-1:0]         free_rd_reg;
    logic [IW-1:0]         free_alt_reg;
    logic                  free_alt_sel_reg;
    // head successor and head payload of the accepted command's queue
    logic [IW-1:0]         hlink_rd_reg;
    logic [IW-1:0]         hlink_byp_reg;
    logic                  hlink_byp_sel_reg;
    logic [DATA_WIDTH-1:0] hdata_rd_reg;
    logic [DATA_WIDTH-1:0] hdata_byp_reg;
    logic                  hdata_byp_sel_reg;

    // output register
    logic                              out_valid_reg;
    logic signed [DATA_PORT_WIDTH-1:0] data_out_reg;
    status_t                           status_reg;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic e_fire;
    logic in_fire;

    assign e_fire   = e_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !e_valid_reg || e_fire;
    assign in_fire  = in_valid && in_ready;

    // ------------------------------------------------------------------
    // execute: one command against the current pointers
    // ------------------------------------------------------------------
    logic [QXW-1:0]              e_qext;
    logic                        e_qok;
    logic [QW-1:0]               e_qsel;
    logic [IW-1:0]               free_link;
    logic [IW-1:0]               head_link;
    logic signed [DATA_WIDTH-1:0] head_data;
    logic [IW-1:0]               cur_head;
    logic [IW-1:0]               cur_tail;
    logic                        cur_nonempty;
    logic                        enq_ok;
    logic                        deq_ok;
    status_t                     e_status;
    logic signed [DATA_PORT_WIDTH-1:0] e_dout;

    // write ports driven by the executing command
    logic          link_we;
    logic [IW-1:0] link_waddr;
    logic [IW-1:0] link_wdata;
    logic          pay_we;
    logic [IW-1:0] pay_waddr;

    always_comb
    begin
        e_qext       = QXW'(e_qid_reg);
        e_qok        = e_qext < QXW'(QUEUES);
        e_qsel       = e_qext[QW-1:0];
        free_link    = free_alt_sel_reg  ? free_alt_reg  : free_rd_reg;
        head_link    = hlink_byp_sel_reg ? hlink_byp_reg : hlink_rd_reg;
        head_data    = hdata_byp_sel_reg ? hdata_byp_reg : hdata_rd_reg;
        cur_head     = e_qok ? head_reg[e_qsel] : '0;
        cur_tail     = e_qok ? tail_reg[e_qsel] : '0;
        cur_nonempty = e_qok ? nonempty_reg[e_qsel] : 1'b0;

        enq_ok = (e_op_reg == OP_ENQ) && e_qok && (free_count_reg != '0);
        deq_ok = (e_op_reg == OP_DEQ) && cur_nonempty;

        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        fresh_next      = fresh_reg;
        nonempty_next   = nonempty_reg;
        for (int i = 0; i < QUEUES; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
        end

        link_we    = 1'b0;
        link_waddr = cur_tail;
        link_wdata = free_head_reg;
        pay_we     = 1'b0;
        pay_waddr  = free_head_reg;

        e_dout   = '0;
        e_status = STATUS_OK;
        if (e_op_reg == OP_ENQ && !enq_ok)
        begin
            e_status = STATUS_FULL;
        end
        else if (e_op_reg == OP_DEQ && !deq_ok)
        begin
            e_status = STATUS_EMPTY;
        end

        if (deq_ok)
        begin
            e_dout = DATA_PORT_WIDTH'(head_data);
        end

        if (e_fire && enq_ok)
        begin
            // take the free head and append it to the queue
            free_head_next  = free_link;
            free_count_next = free_count_reg - CW'(1);
            if (CW'(free_head_reg) == fresh_reg)
            begin
                fresh_next = fresh_reg + CW'(1);
            end
            if (cur_nonempty)
            begin
                link_we    = 1'b1;
                link_waddr = cur_tail;
                link_wdata = free_head_reg;
            end
            else
            begin
                head_next[e_qsel] = free_head_reg;
            end
            tail_next[e_qsel]     = free_head_reg;
            nonempty_next[e_qsel] = 1'b1;
            pay_we    = 1'b1;
            pay_waddr = free_head_reg;
        end
        else if (e_fire && deq_ok)
        begin
            // unlink the head and push it on the free list
            if (cur_head == cur_tail)
            begin
                nonempty_next[e_qsel] = 1'b0;
            end
            else
            begin
                head_next[e_qsel] = head_link;
            end
            link_we        = 1'b1;
            link_waddr     = cur_head;
            link_wdata     = free_head_reg;
            free_head_next = cur_head;
            if (free_count_reg < CW'(DEPTH))
            begin
                free_count_next = free_count_reg + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // read addresses for the next execute cycle, with write bypass
    // ------------------------------------------------------------------
    logic [QXW-1:0] in_qext;
    logic           in_qok;
    logic [IW-1:0]  hd_rd_addr;
    logic [IW-1:0]  free_rd_addr;
    logic [IW-1:0]  free_succ;
    logic           free_is_fresh;
    logic           free_byp;

    always_comb
    begin
        in_qext      = QXW'(queue_id);
        in_qok       = in_qext < QXW'(QUEUES);
        hd_rd_addr   = in_qok ? head_next[in_qext[QW-1:0]] : '0;
        free_rd_addr = free_head_next;
        free_succ    = (free_rd_addr == IW'(DEPTH - 1)) ? '0 : free_rd_addr + IW'(1);
        free_is_fresh = CW'(free_rd_addr) >= fresh_next;
        free_byp     = link_we && (link_waddr == free_rd_addr);
    end

    // memories: one write port each, registered reads
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (pay_we)
        begin
            pay_mem[pay_waddr] <= e_data_reg;
        end
        free_rd_reg <= link_mem[free_rd_addr];
        if (in_fire)
        begin
            hlink_rd_reg <= link_mem[hd_rd_addr];
            hdata_rd_reg <= pay_mem[hd_rd_addr];
        end
    end

    // bypass values and selects for the registered reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_alt_sel_reg  <= 1'b0;
            hlink_byp_sel_reg <= 1'b0;
            hdata_byp_sel_reg <= 1'b0;
        end
        else
        begin
            free_alt_sel_reg <= free_byp || free_is_fresh;
            if (in_fire)
            begin
                hlink_byp_sel_reg <= link_we && (link_waddr == hd_rd_addr);
                hdata_byp_sel_reg <= pay_we && (pay_waddr == hd_rd_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // a same-cycle write wins over the reset successor
        free_alt_reg <= free_byp ? link_wdata : free_succ;
        if (in_fire)
        begin
            hlink_byp_reg <= link_wdata;
            hdata_byp_reg <= e_data_reg;
        end
    end

    // ------------------------------------------------------------------
    // state registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= '0;
            free_count_reg <= CW'(DEPTH);
            fresh_reg      <= '0;
            nonempty_reg   <= '0;
            for (int i = 0; i < QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            fresh_reg      <= fresh_next;
            nonempty_reg   <= nonempty_next;
            for (int i = 0; i < QUEUES; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
            end
        end
    end

    // execute stage and output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (e_fire)
            begin
                e_valid_reg <= 1'b0;
            end
            if (e_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // beat payloads
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            e_op_reg   <= op_t'(op);
            e_qid_reg  <= queue_id;
            e_data_reg <= DATA_WIDTH'(data_in);
        end
        if (e_fire)
        begin
            data_out_reg <= e_dout;
            status_reg   <= e_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // never-issued entries are all on the free list
    a_fresh_free: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg >= CW'(DEPTH) - fresh_reg)
        else $error("free count below never-issued entry count");

    // with every queue empty the whole store is free
    a_all_free: assert property (@(posedge clk) disable iff (!rst_n)
        (nonempty_reg == '0) |-> (free_count_reg == CW'(DEPTH)))
        else $error("entries lost with all queues empty");

    // an error beat carries zero data
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STATUS_OK)) |-> (data_out_reg == '0))
        else $error("error beat with nonzero data");

    // an executed command always lands in the output register
    a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
        e_fire |=> out_valid_reg)
        else $error("executed command produced no result beat");

endmodule

`default_nettype wire

FILE: dv/mqsb_checker.sv
// scoreboard for the multi-queue shared buffer: watches both channels, predicts and compares
`timescale 1ns / 1ps

module mqsb_checker
    import mqsb_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int QUEUES = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              op,
    input  logic [QID_WIDTH-1:0]              queue_id,
    input  logic signed [DATA_PORT_WIDTH-1:0] data_in,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [DATA_PORT_WIDTH-1:0] data_out,
    input  logic [1:0]                        status,
    output int unsigned                       mismatch_count,
    output int unsigned                       pending_results,
    output int unsigned                       results_checked,
    output int unsigned                       full_seen,
    output int unsigned                       empty_seen
);

    localparam int IDX_W        = $clog2(DEPTH);
    localparam int REPORT_LIMIT = 10;

    typedef struct packed
    {
        logic signed [DATA_PORT_WIDTH-1:0] data;
        status_t                           status;
    } queue_result_t;

    // shadow copy of the entry store, the chains and the free list
    logic signed [DATA_PORT_WIDTH-1:0] store_data [DEPTH];
    logic [IDX_W-1:0]                  next_link  [DEPTH];
    logic [IDX_W-1:0]                  free_top;
    int unsigned                       free_left;
    logic [IDX_W-1:0]                  q_head     [QUEUES];
    logic [IDX_W-1:0]                  q_tail     [QUEUES];
    logic                              q_busy     [QUEUES];

    queue_result_t expected_results [$];
    queue_result_t head_result;

    function automatic queue_result_t run_command(
        input op_t                               kind,
        input logic [QID_WIDTH-1:0]              qid,
        input logic signed [DATA_PORT_WIDTH-1:0] value
    );
        queue_result_t    res;
        logic [IDX_W-1:0] idx;
        res.data   = '0;
        res.status = STATUS_OK;
        if (kind == OP_ENQ)
        begin
            if (int'(qid) >= QUEUES || free_left == 0)
                res.status = STATUS_FULL;
            else
            begin
                idx       = free_top;
                free_top  = next_link[idx];
                free_left = free_left - 1;
                if (q_busy[qid])
                    next_link[q_tail[qid]] = idx;
                else
                    q_head[qid] = idx;
                q_tail[qid]    = idx;
                q_busy[qid]    = 1'b1;
                store_data[idx] = value;
            end
        end
        else
        begin
            if (int'(qid) >= QUEUES || !q_busy[qid])
                res.status = STATUS_EMPTY;
            else
            begin
                idx = q_head[qid];
                // last entry leaves the queue empty
                if (idx == q_tail[qid])
                    q_busy[qid] = 1'b0;
                else
                    q_head[qid] = next_link[idx];
                next_link[idx] = free_top;
                free_top       = idx;
                if (free_left < DEPTH)
                    free_left = free_left + 1;
                res.data = store_data[idx];
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                store_data[i] = '0;
                next_link[i]  = IDX_W'((i + 1) % DEPTH);
            end
            for (int i = 0; i < QUEUES; i++)
            begin
                q_head[i] = '0;
                q_tail[i] = '0;
                q_busy[i] = 1'b0;
            end
            free_top  = '0;
            free_left = DEPTH;
            expected_results.delete();
            mismatch_count  <= 0;
            pending_results <= 0;
            results_checked <= 0;
            full_seen       <= 0;
            empty_seen      <= 0;
        end
        else
        begin
            // result side first: a command never comes out on its own accept edge
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: unexpected result beat, data %h status %0d",
                                 $realtime, data_out, status);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    head_result = expected_results.pop_front();
                    results_checked <= results_checked + 1;
                    if (head_result.status == STATUS_FULL)
                        full_seen <= full_seen + 1;
                    if (head_result.status == STATUS_EMPTY)
                        empty_seen <= empty_seen + 1;
                    if (data_out !== head_result.data || status !== head_result.status)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("%0t: mismatch, expected %h/%s, got %h/%0d",
                                     $realtime, head_result.data, head_result.status.name(),
                                     data_out, status);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(run_command(op_t'(op), queue_id, data_in));
            pending_results <= expected_results.size();
        end
    end

endmodule

FILE: dv/tb_multi_queue_shared_buffer.sv
// top-level testbench for the multi-queue shared buffer: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_multi_queue_shared_buffer
    import mqsb_pkg::*;
();

    localparam int RANDOM_ITEMS   = 1950;
    localparam int PHASE_ITEMS    = 150;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;

    logic                              clk      = 1'b0;
    logic                              rst_n    = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    op_t                               cmd_op   = OP_ENQ;
    logic [QID_WIDTH-1:0]              queue_id = '0;
    logic signed [DATA_PORT_WIDTH-1:0] data_in  = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic signed [DATA_PORT_WIDTH-1:0] data_out;
    logic [1:0]                        status;

    int unsigned mismatch_count;
    int unsigned pending_results;
    int unsigned results_checked;
    int unsigned full_seen;
    int unsigned empty_seen;

    // when set, neither side idles: back-to-back beats in and out
    bit          no_idle = 1'b0;
    int unsigned commands_sent = 0;
    int unsigned directed_count = 0;
    int unsigned idle_run = 0;

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    multi_queue_shared_buffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (cmd_op),
        .queue_id  (queue_id),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_out  (data_out),
        .status    (status)
    );

    mqsb_checker scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (cmd_op),
        .queue_id        (queue_id),
        .data_in         (data_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .data_out        (data_out),
        .status          (status),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .full_seen       (full_seen),
        .empty_seen      (empty_seen)
    );

    // idle length: mostly none or short, now and then a long pause
    function automatic int unsigned idle_cycles();
        int unsigned roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // payload: mostly random, with the extremes mixed in
    function automatic logic signed [DATA_PORT_WIDTH-1:0] pick_payload();
        int unsigned roll;
        roll = $urandom_range(0, 15);
        case (roll)
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // present one command beat and hold it until accepted
    task automatic issue_command(
        input op_t                               kind,
        input logic [QID_WIDTH-1:0]              qid,
        input logic signed [DATA_PORT_WIDTH-1:0] value
    );
        int unsigned gap;
        gap = idle_cycles();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd_op   <= kind;
        queue_id <= qid;
        data_in  <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        commands_sent++;
    endtask

    // result side backpressure: runs of ready broken by stalls
    initial
    begin
        int unsigned run_len;
        int unsigned stall;
        forever
        begin
            out_ready <= 1'b1;
            run_len = no_idle ? 8 : $urandom_range(1, 7);
            repeat (run_len) @(posedge clk);
            stall = idle_cycles();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // watchdog: too long without any beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_run <= 0;
        else
        begin
            idle_run <= idle_run + 1;
            if (idle_run == WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned enq_pct;
        int unsigned focus_pct;
        int unsigned focus_q;
        op_t         kind;
        logic [QID_WIDTH-1:0] qid;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // dequeue from queues that were never filled
        issue_command(OP_DEQ, 2'd0, 32'sd0);
        issue_command(OP_DEQ, 2'd3, -32'sd1);
        // extremes of the payload into several queues
        issue_command(OP_ENQ, 2'd0, 32'sh7fff_ffff);
        issue_command(OP_ENQ, 2'd0, 32'sh8000_0000);
        issue_command(OP_ENQ, 2'd1, -32'sd1);
        issue_command(OP_ENQ, 2'd2, 32'sd0);
        // in-order return, then a queue drained of its only entry and read once more
        issue_command(OP_DEQ, 2'd0, 32'sd0);
        issue_command(OP_DEQ, 2'd2, 32'sd0);
        issue_command(OP_DEQ, 2'd2, 32'sd0);
        // two entries in use: fill the rest of the store across all queues
        for (int i = 0; i < 14; i++)
            issue_command(OP_ENQ, QID_WIDTH'(i), pick_payload());
        // store full, then a freed entry is handed out again
        issue_command(OP_ENQ, 2'd2, 32'sh1234_5678);
        issue_command(OP_DEQ, 2'd1, 32'sd0);
        issue_command(OP_ENQ, 2'd1, 32'sh0bad_f00d);
        issue_command(OP_DEQ, 2'd0, 32'sd0);
        directed_count = commands_sent;

        // ---- random part ----
        // phases cycle through fill-heavy, drain-heavy and balanced mixes,
        // some aimed mostly at one queue, every fourth with no idling at all
        for (int p = 0; p < RANDOM_ITEMS / PHASE_ITEMS; p++)
        begin
            case (p % 3)
                0: enq_pct = 75;
                1: enq_pct = 25;
                default: enq_pct = 50;
            endcase
            no_idle   = (p % 4 == 1);
            focus_q   = $urandom_range(0, 3);
            focus_pct = $urandom_range(0, 1) ? 70 : 0;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                kind = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
                if ($urandom_range(0, 99) < focus_pct)
                    qid = QID_WIDTH'(focus_q);
                else
                    qid = QID_WIDTH'($urandom_range(0, 3));
                issue_command(kind, qid, pick_payload());
            end
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        // wait for every outstanding result, then let the pipeline settle
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d commands issued (%0d directed), %0d results checked",
                 commands_sent, directed_count, results_checked);
        $display("store-full answers %0d, empty-queue answers %0d, mismatches %0d",
                 full_seen, empty_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
